@@ hw/rtl/hcbd_pkg.sv @@
// Shared types, character codes and helpers for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

	// Default width of the chunk-size counter.
	localparam int unsigned SIZE_BITS_DEF = 32;

	// Characters that frame size lines and chunk data.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Decoder phase.
	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_EXT     = 3'd1,
		PH_SIZE_LF = 3'd2,
		PH_DATA    = 3'd3,
		PH_DATA_CR = 3'd4,
		PH_DATA_LF = 3'd5,
		PH_DONE    = 3'd6,
		PH_ERR     = 3'd7
	} phase_t;

	// Kind of a result word.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// One result of the decoder step.
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	// Hex digit decode: bit 4 flags a digit, bits 3:0 carry its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hcbd_step.sv @@
// Per-byte decoder state machine with the chunk-size counter.
`default_nettype none

module hcbd_step
	import hcbd_pkg::*;
#(
	parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] c,
	input  wire logic       start,
	output res_t            res
);

	phase_t               phase_q, ph, ph_n;
	logic [SIZE_BITS-1:0] rem_q, rem, rem_n;
	logic                 dig_q, dig, dig_n;
	logic [4:0]           hx;
	logic                 is_hex;
	logic                 ovf;
	logic                 rem_zero;
	logic                 rem_one;

	// A new body clears the state before the byte is taken.
	assign ph  = start ? PH_SIZE : phase_q;
	assign rem = start ? '0 : rem_q;
	assign dig = start ? 1'b0 : dig_q;

	assign hx       = hex_decode(c);
	assign is_hex   = hx[4];
	assign ovf      = (rem[SIZE_BITS-1 -: 4] != 4'd0);
	assign rem_zero = (rem == '0);
	assign rem_one  = (rem == SIZE_BITS'(1));

	// Next state.
	always_comb begin
		ph_n  = ph;
		rem_n = rem;
		dig_n = dig;
		case (ph)
			PH_SIZE: begin
				if (is_hex) begin
					if (ovf) begin
						ph_n = PH_ERR;
					end else begin
						rem_n = {rem[SIZE_BITS-5:0], hx[3:0]};
						dig_n = 1'b1;
					end
				end else if (!dig) begin
					ph_n = PH_ERR;
				end else begin
					ph_n = (c == CH_CR) ? PH_SIZE_LF : PH_EXT;
				end
			end
			PH_EXT: begin
				if (c == CH_CR) begin
					ph_n = PH_SIZE_LF;
				end
			end
			PH_SIZE_LF: begin
				if (c != CH_LF) begin
					ph_n = PH_ERR;
				end else if (rem_zero) begin
					ph_n = PH_DONE;
				end else begin
					ph_n = PH_DATA;
				end
			end
			PH_DATA: begin
				rem_n = rem - SIZE_BITS'(1);
				if (rem_one) begin
					ph_n = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				ph_n = (c != CH_CR) ? PH_ERR : PH_DATA_LF;
			end
			PH_DATA_LF: begin
				if (c != CH_LF) begin
					ph_n = PH_ERR;
				end else begin
					ph_n  = PH_SIZE;
					rem_n = '0;
					dig_n = 1'b0;
				end
			end
			default: begin
				ph_n = ph;
			end
		endcase
	end

	// Result of this byte, if any.
	always_comb begin
		res = '{vld: 1'b0, data: 8'd0, kind: KIND_DATA};
		case (ph)
			PH_SIZE: begin
				if ((is_hex && ovf) || (!is_hex && !dig)) begin
					res = '{vld: 1'b1, data: 8'd0, kind: KIND_ERR};
				end
			end
			PH_SIZE_LF: begin
				if (c != CH_LF) begin
					res = '{vld: 1'b1, data: 8'd0, kind: KIND_ERR};
				end else if (rem_zero) begin
					res = '{vld: 1'b1, data: 8'd0, kind: KIND_END};
				end
			end
			PH_DATA: begin
				res = '{vld: 1'b1, data: c, kind: KIND_DATA};
			end
			PH_DATA_CR: begin
				if (c != CH_CR) begin
					res = '{vld: 1'b1, data: 8'd0, kind: KIND_ERR};
				end
			end
			PH_DATA_LF: begin
				if (c != CH_LF) begin
					res = '{vld: 1'b1, data: 8'd0, kind: KIND_ERR};
				end
			end
			default: begin
				res = '{vld: 1'b0, data: 8'd0, kind: KIND_DATA};
			end
		endcase
	end

	// State registers advance once per byte taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			rem_q   <= '0;
			dig_q   <= 1'b0;
		end else if (en) begin
			phase_q <= ph_n;
			rem_q   <= rem_n;
			dig_q   <= dig_n;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/http_chunked_body_decoder.sv @@
// Top level of the HTTP/1.1 chunked body decoder: input register, step logic, result register.
`default_nettype none

// The decoder takes one body byte per cycle and gives at most one result word per byte:
// a payload byte, an end-of-body mark after the zero-size chunk, or a format error. A byte
// lands in an input register, the state machine and size counter work on it there, and
// its result is then held in the output register; throughput is one byte per cycle while
// out_ready stays high. The input register takes a new word whenever it is empty or its
// word moves on, so in_ready follows out_ready combinationally only while both registers
// hold a word.
// After an error or the end of a body, bytes are swallowed until start_body is set.
module http_chunked_body_decoder
	import hcbd_pkg::*;
#(
	parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_body,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	kind_t      kind_q;
	logic       adv;
	res_t       res;

	// The stage-one word moves on when the result register is free or being drained.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			start_s1 <= start_body;
		end
	end

	hcbd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.c     (data_s1),
		.start (start_s1),
		.res   (res)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.vld;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv && res.vld) begin
			out_byte_q <= res.data;
			kind_q     <= res.kind;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign kind      = kind_q;

	// An empty input register always takes a word.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

	// A stalled stage-one word is neither lost nor changed.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1) && $stable(start_s1))
		else $error("stalled input word changed");

	// End and error marks carry a zero byte.
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_DATA) |-> out_byte == 8'd0)
		else $error("non-payload result with nonzero byte");

endmodule

`default_nettype wire

@@ tb/tb_http_chunked_body_decoder.sv @@
// Self-checking testbench for the chunked body decoder: directed and random bodies, checked per word.
module tb_http_chunked_body_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import hcbd_pkg::*;

	localparam int SIZE_BITS    = SIZE_BITS_DEF;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 300;

	// One expected result word.
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} dec_word_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte  = 8'h00;
	logic       start_body = 1'b0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;

	// Decoder state as the testbench tracks it.
	phase_t               dec_phase = PH_SIZE;
	logic [SIZE_BITS-1:0] dec_left  = '0;
	logic                 dec_digit = 1'b0;

	dec_word_t pending_words[$];

	int err_cnt       = 0;
	int bytes_sent    = 0;
	int bytes_in      = 0;
	int words_checked = 0;
	int ends_seen     = 0;
	int faults_seen   = 0;
	int stall_cnt     = 0;
	int snd_idle_pct  = 0;
	int rcv_idle_pct  = 0;
	int hold_arm      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	http_chunked_body_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.start_body(start_body),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.kind      (kind)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Advance the tracked decoder state by one byte; returns 1 when the byte yields a word.
	function automatic bit chunk_decode_step(input logic [7:0] c, input logic sb,
			output dec_word_t w);
		logic       is_hex;
		logic [7:0] nib;
		bit         hit;
		bit         bad;
		w.data = 8'h00;
		w.kind = KIND_DATA;
		hit = 1'b0;
		bad = 1'b0;
		is_hex = 1'b1;
		if (c >= "0" && c <= "9") begin
			nib = c - "0";
		end else if (c >= "A" && c <= "F") begin
			nib = c - "A" + 8'd10;
		end else if (c >= "a" && c <= "f") begin
			nib = c - "a" + 8'd10;
		end else begin
			nib = 8'h00;
			is_hex = 1'b0;
		end
		if (sb) begin
			dec_phase = PH_SIZE;
			dec_left = '0;
			dec_digit = 1'b0;
		end
		case (dec_phase)
			PH_SIZE: begin
				if (is_hex) begin
					// A digit that would shift bits out of the counter is an overflow.
					if (dec_left[SIZE_BITS-1 -: 4] != 4'h0) begin
						bad = 1'b1;
					end else begin
						dec_left = {dec_left[SIZE_BITS-5:0], nib[3:0]};
						dec_digit = 1'b1;
					end
				end else if (!dec_digit) begin
					bad = 1'b1;
				end else begin
					dec_phase = (c == CH_CR) ? PH_SIZE_LF : PH_EXT;
				end
			end
			PH_EXT: begin
				if (c == CH_CR) begin
					dec_phase = PH_SIZE_LF;
				end
			end
			PH_SIZE_LF: begin
				if (c != CH_LF) begin
					bad = 1'b1;
				end else if (dec_left == '0) begin
					dec_phase = PH_DONE;
					w.kind = KIND_END;
					hit = 1'b1;
				end else begin
					dec_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				dec_left = dec_left - 1'b1;
				if (dec_left == '0) begin
					dec_phase = PH_DATA_CR;
				end
				w.data = c;
				hit = 1'b1;
			end
			PH_DATA_CR: begin
				if (c != CH_CR) begin
					bad = 1'b1;
				end else begin
					dec_phase = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				if (c != CH_LF) begin
					bad = 1'b1;
				end else begin
					dec_phase = PH_SIZE;
					dec_left = '0;
					dec_digit = 1'b0;
				end
			end
			default: ;
		endcase
		if (bad) begin
			dec_phase = PH_ERR;
			w.data = 8'h00;
			w.kind = KIND_ERR;
			hit = 1'b1;
		end
		return hit;
	endfunction

	// Check each result word against the oldest expectation, then predict for the new byte.
	always @(posedge clk) begin : scoreboard
		dec_word_t exp_w;
		dec_word_t new_w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					$error("unexpected word: out_byte %02h, kind %0d", out_byte, kind);
					err_cnt++;
				end else begin
					exp_w = pending_words.pop_front();
					words_checked++;
					if (exp_w.kind == KIND_END) ends_seen++;
					if (exp_w.kind == KIND_ERR) faults_seen++;
					if (out_byte !== exp_w.data) begin
						$error("out_byte mismatch: expected %02h, got %02h", exp_w.data, out_byte);
						err_cnt++;
					end
					if (kind !== exp_w.kind) begin
						$error("kind mismatch: expected %0d, got %0d", exp_w.kind, kind);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				bytes_in++;
				if (chunk_decode_step(data_byte, start_body, new_w)) begin
					pending_words.insert(pending_words.size(), new_w);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cnt = 0;
			end else begin
				stall_cnt++;
				if (stall_cnt >= STALL_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	// Output side: random stalls, plus a long hold-off whenever the test arms one.
	always @(negedge clk) begin
		if (hold_arm != hold_seen) begin
			hold_seen = hold_arm;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Offer one word after a random gap and wait until it is taken.
	task automatic send_word(input logic [7:0] b, input logic first);
		int gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		start_body <= first;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic first);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], first && (i == 0));
		end
	endtask

	task automatic send_crlf();
		send_word(CH_CR, 1'b0);
		send_word(CH_LF, 1'b0);
	endtask

	// Hex digit in either letter case.
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return "0" + 8'(v);
		return (($urandom_range(1) == 0) ? "A" : "a") + 8'(v) - 8'd10;
	endfunction

	// One random body: mostly well formed, some broken or oversized, some plain noise.
	task automatic send_random_body();
		logic [7:0] body[$];
		logic [7:0] ch;
		int         style;
		int         n_chunks;
		int         sz;
		int         nd;
		int         pos;
		style = $urandom_range(99);
		if (style < 8) begin
			repeat ($urandom_range(1, 12)) send_word(8'($urandom), $urandom_range(3) == 0);
			return;
		end
		n_chunks = $urandom_range(0, 3);
		for (int k = 0; k <= n_chunks; k++) begin
			if (k == n_chunks) sz = 0;
			else if ($urandom_range(9) == 0) sz = $urandom_range(16, 64);
			else sz = $urandom_range(1, 8);
			if (style < 13 && k == 0) begin
				// Nine or ten digits with a nonzero lead cannot fit the counter.
				body.insert(body.size(), "0" + 8'($urandom_range(1, 9)));
				repeat ($urandom_range(8, 9))
					body.insert(body.size(), hex_char(4'($urandom)));
			end else begin
				repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
					body.insert(body.size(), "0");
				nd = 1;
				while ((sz >> (4 * nd)) != 0) nd++;
				for (int i = nd - 1; i >= 0; i--)
					body.insert(body.size(), hex_char(4'(sz >> (4 * i))));
			end
			// Optional extension text up to the CR.
			if ($urandom_range(3) == 0) begin
				body.insert(body.size(), ";");
				repeat ($urandom_range(0, 4)) begin
					ch = 8'($urandom);
					body.insert(body.size(), (ch == CH_CR) ? 8'h20 : ch);
				end
			end
			body.insert(body.size(), CH_CR);
			body.insert(body.size(), CH_LF);
			repeat (sz) body.insert(body.size(), 8'($urandom));
			if (sz != 0) begin
				body.insert(body.size(), CH_CR);
				body.insert(body.size(), CH_LF);
			end
		end
		// Trailer lines after the last chunk are swallowed.
		if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(1, 6)) body.insert(body.size(), 8'($urandom));
			body.insert(body.size(), CH_CR);
			body.insert(body.size(), CH_LF);
		end
		// Broken bodies: one byte replaced, or the body cut short.
		if (style >= 13 && style < 22) begin
			pos = $urandom_range(body.size() - 1);
			if ($urandom_range(1) == 0) begin
				body[pos] = 8'($urandom);
			end else begin
				while (body.size() > pos + 1) void'(body.pop_back());
			end
		end
		foreach (body[i]) send_word(body[i], i == 0);
	endtask

	task automatic run_random_phase(input int snd_pct, input int rcv_pct, input int n_items);
		int stop_at;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at) send_random_body();
	endtask

	// Hand-picked bodies for each framing rule and fault.
	task automatic test_directed();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		// Full body: the byte extremes, the last chunk, then ignored trailer.
		send_text("2", 1'b1);
		send_crlf();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_crlf();
		send_text("0", 1'b0);
		send_crlf();
		send_text("T", 1'b0);
		// Size line without digits; the byte after the fault is ignored.
		send_text("G!", 1'b1);
		// A CR as the first byte of a size line.
		send_word(CH_CR, 1'b1);
		// Size overflow with mixed-case digits.
		send_text("aBcDeF012", 1'b1);
		// Extension text, then data not followed by CR.
		send_text("1;z", 1'b1);
		send_crlf();
		send_text("QZ", 1'b0);
		// Bare CR on the size line.
		send_text("1", 1'b1);
		send_word(CH_CR, 1'b0);
		send_text("A", 1'b0);
	endtask

	task automatic test_streaming();
		run_random_phase(0, 0, PHASE_ITEMS);
	endtask

	task automatic test_sender_gaps();
		run_random_phase(86, 0, PHASE_ITEMS);
	endtask

	task automatic test_receiver_stalls();
		run_random_phase(0, 86, PHASE_ITEMS);
	endtask

	// Long output hold-off while the input keeps offering, so the pipeline backs up.
	task automatic test_output_stall();
		hold_arm++;
		run_random_phase(0, 0, 80);
	endtask

	task automatic test_mixed_idle();
		run_random_phase(15, 15, PHASE_ITEMS);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_output_stall();
		test_mixed_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d body bytes and %0d result words (%0d end marks, %0d faults),",
			bytes_in, words_checked, ends_seen, faults_seen);
		$display("under four idle profiles and one long output hold-off.");
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
